/* hw/rtl/pcim_pkg.sv */
// Shared types, constants and register codes for the pixel color index mapper.
`default_nettype none

package pcim_pkg;

  // Default palette size
  localparam int unsigned PALETTE_SIZE_DEF = 256;

  // Sample, gain and offset format (signed Q16.16)
  localparam int unsigned Q_W      = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * Q_W;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned COUNTS_W = 3 * LEVEL_W;
  localparam int unsigned INDEX_W  = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_RED_GAIN     = 3'd1,
    REG_RED_OFFSET   = 3'd2,
    REG_GREEN_GAIN   = 3'd3,
    REG_GREEN_OFFSET = 3'd4,
    REG_BLUE_GAIN    = 3'd5,
    REG_BLUE_OFFSET  = 3'd6,
    REG_LEVEL_COUNTS = 3'd7
  } cfg_reg_t;

  // Mode codes
  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_CUBE   = 1'b1;

  // Reset values
  localparam logic signed [Q_W-1:0]  GAIN_RST   = 32'sd65536;
  localparam logic signed [Q_W-1:0]  OFFSET_RST = 32'sd0;
  localparam logic [COUNTS_W-1:0]    COUNTS_RST = 24'd263172;

  // Register file contents
  typedef struct packed {
    logic                     mode;
    logic signed [Q_W-1:0]    red_gain;
    logic signed [Q_W-1:0]    red_offset;
    logic signed [Q_W-1:0]    green_gain;
    logic signed [Q_W-1:0]    green_offset;
    logic signed [Q_W-1:0]    blue_gain;
    logic signed [Q_W-1:0]    blue_offset;
    logic [COUNTS_W-1:0]      level_counts;
  } cfg_t;

  // Stage enables for the channel lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } lane_en_t;

  // Stage enables for the merge stage
  typedef struct packed {
    logic m1_en;
    logic m2_en;
  } merge_en_t;

endpackage

`default_nettype wire

/* hw/rtl/pcim_in_if.sv */
// Pixel request channel: valid/ready plus three samples and their bad flags.
`default_nettype none

interface pcim_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] red_sample;
  logic signed [31:0] green_sample;
  logic signed [31:0] blue_sample;
  logic               red_bad;
  logic               green_bad;
  logic               blue_bad;

  modport source (
    output valid, red_sample, green_sample, blue_sample, red_bad, green_bad, blue_bad,
    input  ready
  );
  modport sink (
    input  valid, red_sample, green_sample, blue_sample, red_bad, green_bad, blue_bad,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/pcim_out_if.sv */
// Result channel: valid/ready plus the palette index.
`default_nettype none

interface pcim_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (
    output valid, color_index,
    input  ready
  );
  modport sink (
    input  valid, color_index,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/pcim_cfg.sv */
// Configuration register file with reset values.
`default_nettype none

module pcim_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pcim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcim_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pcim_pkg::cfg_t                        cfg
);
  import pcim_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:         cfg_nxt.mode         = cfg_wdata[0];
        REG_RED_GAIN:     cfg_nxt.red_gain     = cfg_wdata;
        REG_RED_OFFSET:   cfg_nxt.red_offset   = cfg_wdata;
        REG_GREEN_GAIN:   cfg_nxt.green_gain   = cfg_wdata;
        REG_GREEN_OFFSET: cfg_nxt.green_offset = cfg_wdata;
        REG_BLUE_GAIN:    cfg_nxt.blue_gain    = cfg_wdata;
        REG_BLUE_OFFSET:  cfg_nxt.blue_offset  = cfg_wdata;
        REG_LEVEL_COUNTS: cfg_nxt.level_counts = cfg_wdata[COUNTS_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_SINGLE;
      cfg_r.red_gain     <= GAIN_RST;
      cfg_r.red_offset   <= OFFSET_RST;
      cfg_r.green_gain   <= GAIN_RST;
      cfg_r.green_offset <= OFFSET_RST;
      cfg_r.blue_gain    <= GAIN_RST;
      cfg_r.blue_offset  <= OFFSET_RST;
      cfg_r.level_counts <= COUNTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* hw/rtl/pcim_lane.sv */
// One channel lane: sample*gain, subtract offset, truncate and clamp.
`default_nettype none

module pcim_lane #(
  parameter int unsigned MAXW = 8
) (
  input  wire logic                              clk,
  input  pcim_pkg::lane_en_t                     en,
  input  wire logic signed [pcim_pkg::Q_W-1:0]   sample,
  input  wire logic signed [pcim_pkg::Q_W-1:0]   gain,
  input  wire logic signed [pcim_pkg::Q_W-1:0]   offset,
  input  wire logic [MAXW-1:0]                   maxv,
  output logic [MAXW-1:0]                        level
);
  import pcim_pkg::*;

  localparam int unsigned WHOLE_W = PROD_W - Q_W - 1;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] val_r;
  logic signed [PROD_W-1:0] val_nxt;
  logic [MAXW-1:0]          level_r;
  logic [MAXW-1:0]          level_nxt;
  logic [WHOLE_W-1:0]       whole;

  // Stage 1: Q32.32 product
  assign prod_nxt = PROD_W'(sample) * PROD_W'(gain);

  // Stage 2: subtract offset aligned to Q32.32
  assign val_nxt = prod_r - (PROD_W'(offset) <<< FRAC_W);

  // Stage 3: negative gives 0, else integer part clamped to maxv
  assign whole = val_r[PROD_W-2:Q_W];
  always_comb begin
    if (val_r[PROD_W-1]) begin
      level_nxt = '0;
    end else if (whole > WHOLE_W'(maxv)) begin
      level_nxt = maxv;
    end else begin
      level_nxt = whole[MAXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1_en) prod_r  <= prod_nxt;
    if (en.s2_en) val_r   <= val_nxt;
    if (en.s3_en) level_r <= level_nxt;
  end

  assign level = level_r;

endmodule

`default_nettype wire

/* hw/rtl/pcim_merge.sv */
// Merge stage: combine three cube levels, saturate, select bad/single/cube index.
`default_nettype none

module pcim_merge #(
  parameter int unsigned PALETTE_SIZE = pcim_pkg::PALETTE_SIZE_DEF,
  parameter int unsigned IDXW         = 8,
  parameter int unsigned MAXW         = 8
) (
  input  wire logic                            clk,
  input  pcim_pkg::merge_en_t                  en,
  input  wire logic                            mode,
  input  wire logic                            bad,
  input  wire logic [MAXW-1:0]                 red_level,
  input  wire logic [MAXW-1:0]                 green_level,
  input  wire logic [MAXW-1:0]                 blue_level,
  input  wire logic [pcim_pkg::LEVEL_W-1:0]    green_count,
  input  wire logic [pcim_pkg::LEVEL_W-1:0]    blue_count,
  output logic [IDXW-1:0]                      index
);
  import pcim_pkg::*;

  localparam int unsigned PART_W = 2 * LEVEL_W;
  localparam int unsigned SUM_W  = 3 * LEVEL_W + 1;
  localparam logic [IDXW-1:0]  BAD_INDEX = IDXW'(PALETTE_SIZE - 1);
  localparam logic [IDXW-1:0]  MAX_INDEX = IDXW'(PALETTE_SIZE - 2);
  localparam logic [SUM_W-1:0] MAX_SUM   = SUM_W'(PALETTE_SIZE - 2);

  logic              bad_r;
  logic [MAXW-1:0]   red_r;
  logic [PART_W-1:0] gb_r;
  logic [PART_W-1:0] gb_nxt;
  logic [PART_W-1:0] rg_r;
  logic [PART_W-1:0] rg_nxt;
  logic [SUM_W-1:0]  sum;
  logic [IDXW-1:0]   cube_idx;
  logic [IDXW-1:0]   index_r;
  logic [IDXW-1:0]   index_nxt;

  // M1: green + blue*ng and red*ng
  assign gb_nxt = PART_W'(green_level[LEVEL_W-1:0])
                + PART_W'(blue_level[LEVEL_W-1:0]) * PART_W'(green_count);
  assign rg_nxt = PART_W'(red_level[LEVEL_W-1:0]) * PART_W'(green_count);

  // M2: add red*ng*nb, saturate to top usable entry
  assign sum      = SUM_W'(gb_r) + SUM_W'(rg_r) * SUM_W'(blue_count);
  assign cube_idx = (sum > MAX_SUM) ? MAX_INDEX : sum[IDXW-1:0];

  always_comb begin
    if (bad_r) begin
      index_nxt = BAD_INDEX;
    end else if (mode == MODE_CUBE) begin
      index_nxt = cube_idx;
    end else begin
      index_nxt = red_r[IDXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.m1_en) begin
      bad_r <= bad;
      red_r <= red_level;
      gb_r  <= gb_nxt;
      rg_r  <= rg_nxt;
    end
    if (en.m2_en) index_r <= index_nxt;
  end

  assign index = index_r;

endmodule

`default_nettype wire

/* hw/rtl/pixel_color_index_mapper.sv */
// Top level of the pixel color index mapper: config, three lanes, merge, flow control.
`default_nettype none

// Maps one pixel per clock to a palette index. Single mode scales the red
// sample (sample*gain - offset, Q16.16) and clamps it to 0..PALETTE_SIZE-2;
// cube mode scales all three samples in parallel lanes, clamps each to its
// level count minus one and combines them as g + b*ng + r*ng*nb, saturated
// to PALETTE_SIZE-2. A bad sample that is examined gives PALETTE_SIZE-1;
// color_index carries the low 8 bits of the index. The stages are
// multiply, offset subtract and clamp in each lane, then two merge stages,
// and a new pixel is taken every cycle; each stage holds only while the
// stage after it is full and stalled. Configuration takes effect on pixels
// accepted after the write and must be written while the pipeline is empty.
module pixel_color_index_mapper #(
  parameter int unsigned PALETTE_SIZE = pcim_pkg::PALETTE_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  pcim_in_if.sink                               in_px,
  pcim_out_if.source                            out_px,
  input  wire logic                             cfg_we,
  input  wire logic [pcim_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pcim_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pcim_pkg::*;

  localparam int unsigned IDXW   = $clog2(PALETTE_SIZE);
  localparam int unsigned MAXW   = (IDXW > LEVEL_W) ? IDXW : LEVEL_W;
  localparam int unsigned STAGES = 5;
  localparam logic [MAXW-1:0] MAX_INDEX = MAXW'(PALETTE_SIZE - 2);

  cfg_t              cfg;
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES:0]   en;
  logic [2:0]        bad_r;
  logic              bad_in;
  lane_en_t          lane_en;
  merge_en_t         merge_en;
  logic [LEVEL_W-1:0] red_cnt;
  logic [LEVEL_W-1:0] green_cnt;
  logic [LEVEL_W-1:0] blue_cnt;
  logic [MAXW-1:0]   red_max;
  logic [MAXW-1:0]   red_level;
  logic [MAXW-1:0]   green_level;
  logic [MAXW-1:0]   blue_level;
  logic [IDXW-1:0]   index;

  pcim_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[STAGES] = out_px.ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = in_px.valid;
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) v_r[i] <= v_nxt[i];
      end
    end
  end

  assign in_px.ready = en[0];
  assign lane_en     = '{s1_en: en[0], s2_en: en[1], s3_en: en[2]};
  assign merge_en    = '{m1_en: en[3], m2_en: en[4]};

  // Bad flag of the examined samples, carried alongside the lanes
  assign bad_in = (cfg.mode == MODE_CUBE)
                ? (in_px.red_bad || in_px.green_bad || in_px.blue_bad)
                : in_px.red_bad;

  always_ff @(posedge clk) begin
    if (en[0]) bad_r[0] <= bad_in;
    if (en[1]) bad_r[1] <= bad_r[0];
    if (en[2]) bad_r[2] <= bad_r[1];
  end

  // Level counts, zero read as one
  assign red_cnt   = (cfg.level_counts[23:16] == '0) ? LEVEL_W'(1) : cfg.level_counts[23:16];
  assign green_cnt = (cfg.level_counts[15:8] == '0)  ? LEVEL_W'(1) : cfg.level_counts[15:8];
  assign blue_cnt  = (cfg.level_counts[7:0] == '0)   ? LEVEL_W'(1) : cfg.level_counts[7:0];

  assign red_max = (cfg.mode == MODE_CUBE) ? MAXW'(red_cnt - LEVEL_W'(1)) : MAX_INDEX;

  // Channel lanes
  pcim_lane #(.MAXW(MAXW)) u_lane_red (
    .clk    (clk),
    .en     (lane_en),
    .sample (in_px.red_sample),
    .gain   (cfg.red_gain),
    .offset (cfg.red_offset),
    .maxv   (red_max),
    .level  (red_level)
  );

  pcim_lane #(.MAXW(MAXW)) u_lane_green (
    .clk    (clk),
    .en     (lane_en),
    .sample (in_px.green_sample),
    .gain   (cfg.green_gain),
    .offset (cfg.green_offset),
    .maxv   (MAXW'(green_cnt - LEVEL_W'(1))),
    .level  (green_level)
  );

  pcim_lane #(.MAXW(MAXW)) u_lane_blue (
    .clk    (clk),
    .en     (lane_en),
    .sample (in_px.blue_sample),
    .gain   (cfg.blue_gain),
    .offset (cfg.blue_offset),
    .maxv   (MAXW'(blue_cnt - LEVEL_W'(1))),
    .level  (blue_level)
  );

  // Merge of the lane levels
  pcim_merge #(
    .PALETTE_SIZE (PALETTE_SIZE),
    .IDXW         (IDXW),
    .MAXW         (MAXW)
  ) u_merge (
    .clk         (clk),
    .en          (merge_en),
    .mode        (cfg.mode),
    .bad         (bad_r[2]),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .green_count (green_cnt),
    .blue_count  (blue_cnt),
    .index       (index)
  );

  assign out_px.valid       = v_r[STAGES-1];
  assign out_px.color_index = INDEX_W'(index);

`ifndef SYNTHESIS
  // An empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_px.valid |-> in_px.ready)
    else $error("input stalled with empty output stage");

  // An accepted request always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_px.valid && in_px.ready) |=> v_r[0])
    else $error("accepted request lost at first stage");

  // A full stage that could not move keeps its request
  a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !en[2]) |=> v_r[2])
    else $error("stalled lane stage dropped its request");
`endif

endmodule

`default_nettype wire
